[src/itre_pkg.sv]
// ----------------------------------------------------------------------------
// itre_pkg
// Shared types, symbol codes and digit pattern functions for the
// integer to roman numeral encoder.
// ----------------------------------------------------------------------------
package itre_pkg;

   localparam int VALUE_W     = 12;
   localparam int SYMBOL_W    = 3;
   localparam int DIGITS      = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

   // numeral codes
   localparam logic [SYMBOL_W-1:0] SYM_I = 3'd0;
   localparam logic [SYMBOL_W-1:0] SYM_V = 3'd1;
   localparam logic [SYMBOL_W-1:0] SYM_X = 3'd2;
   localparam logic [SYMBOL_W-1:0] SYM_L = 3'd3;
   localparam logic [SYMBOL_W-1:0] SYM_C = 3'd4;
   localparam logic [SYMBOL_W-1:0] SYM_D = 3'd5;
   localparam logic [SYMBOL_W-1:0] SYM_M = 3'd6;

   // decimal digits, index 0 is thousands, index 3 is units
   typedef logic [DIGITS-1:0][3:0] digits_type;

   typedef struct packed {
      logic       err;
      digits_type digits;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   // number of symbols that one digit produces, up to four for an eight
   function automatic logic [2:0] digit_len(input logic [3:0] d);
      logic [2:0] len;
      case (d)
         4'd0: len = 3'd0;
         4'd1, 4'd2, 4'd3: len = {1'b0, d[1:0]};
         4'd4: len = 3'd2;
         4'd5: len = 3'd1;
         4'd6, 4'd7, 4'd8: len = 3'(d - 4'd4);
         4'd9: len = 3'd2;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

   // symbol number k of digit d at decimal place pos
   function automatic logic [SYMBOL_W-1:0] digit_symbol(input logic [3:0] d,
                                                        input logic [1:0] k,
                                                        input logic [1:0] pos);
      logic [SYMBOL_W-1:0] one;
      logic [SYMBOL_W-1:0] five;
      logic [SYMBOL_W-1:0] ten;
      logic [SYMBOL_W-1:0] sym;
      one  = SYM_M - {pos, 1'b0};
      five = one + 3'd1;
      ten  = one + 3'd2;
      case (d)
         4'd4: sym = (k == 2'd0) ? one : five;
         4'd5: sym = five;
         4'd6, 4'd7, 4'd8: sym = (k == 2'd0) ? five : one;
         4'd9: sym = (k == 2'd0) ? one : ten;
         default: sym = one;
      endcase
      return sym;
   endfunction

   // first digit at or after start that is nonzero: {found, index}
   function automatic logic [2:0] find_nonzero(input digits_type digits,
                                               input logic [2:0] start);
      logic [2:0] res;
      res = 3'd0;
      for (int i = DIGITS - 1; i >= 0; i--) begin
         if ((3'(i) >= start) && (digits[i] != 4'd0)) begin
            res = {1'b1, 2'(i)};
         end
      end
      return res;
   endfunction

endpackage

[src/itre_front.sv]
// ----------------------------------------------------------------------------
// itre_front
// Range check and binary to decimal split of one incoming value.
// ----------------------------------------------------------------------------
module itre_front (
   input  logic [itre_pkg::VALUE_W-1:0] value,
   output itre_pkg::entry_type          entry
);

   logic [1:0]                   th;
   logic [3:0]                   hu;
   logic [3:0]                   te;
   logic [itre_pkg::VALUE_W-1:0] r1;
   logic [itre_pkg::VALUE_W-1:0] r2;

   always_comb begin
      th = 2'd0;
      if (value >= 12'd3000) begin
         th = 2'd3;
      end else if (value >= 12'd2000) begin
         th = 2'd2;
      end else if (value >= 12'd1000) begin
         th = 2'd1;
      end

      case (th)
         2'd1: r1 = value - 12'd1000;
         2'd2: r1 = value - 12'd2000;
         2'd3: r1 = value - 12'd3000;
         default: r1 = value;
      endcase

      // parallel compares against the multiples of each place weight
      hu = 4'd0;
      for (int i = 1; i < 10; i++) begin
         if (r1 >= 12'(i * 100)) hu = 4'(i);
      end
      r2 = r1 - 12'(hu) * 12'd100;

      te = 4'd0;
      for (int i = 1; i < 10; i++) begin
         if (r2 >= 12'(i * 10)) te = 4'(i);
      end

      entry.err       = (value == '0) || (value > itre_pkg::MAX_VALUE);
      entry.digits[0] = {2'b00, th};
      entry.digits[1] = hu;
      entry.digits[2] = te;
      entry.digits[3] = 4'(r2 - 12'(te) * 12'd10);
   end

endmodule

[src/itre_queue.sv]
// ----------------------------------------------------------------------------
// itre_queue
// Short fifo of classified values between front and back.
// ----------------------------------------------------------------------------
module itre_queue #(
   parameter int Depth = itre_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  itre_pkg::entry_type push_entry,
   output logic                full,
   output itre_pkg::head_type  head,
   input  logic                pop
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   itre_pkg::entry_type mem_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                push;

   assign full       = (count_ff == CntW'(Depth));
   assign push       = push_valid && !full;
   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue fill beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");

endmodule

[src/itre_back.sv]
// ----------------------------------------------------------------------------
// itre_back
// Symbol sequencer: walks the digits of one entry and emits one symbol
// per cycle into the result register, unless a stalled beat holds that register.
// ----------------------------------------------------------------------------
module itre_back (
   input  logic                          clock,
   input  logic                          reset,
   input  itre_pkg::head_type            head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [itre_pkg::SYMBOL_W-1:0] rsp_symbol,
   output logic                          rsp_last,
   output logic                          rsp_range_error
);

   logic                          busy_ff, busy_in;
   itre_pkg::entry_type           cur_ff, cur_in;
   logic [1:0]                    pos_ff, pos_in;
   logic [1:0]                    k_ff, k_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [itre_pkg::SYMBOL_W-1:0] rsp_symbol_ff, rsp_symbol_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_err_ff, rsp_err_in;

   logic [3:0]                    cur_digit;
   logic [2:0]                    cur_len;
   logic [itre_pkg::SYMBOL_W-1:0] cur_sym;
   logic [2:0]                    after;
   logic [2:0]                    first;
   logic                          digit_done;
   logic                          last_sym;
   logic                          out_free;
   logic                          emit;
   logic                          load;

   always_comb begin
      cur_digit  = cur_ff.digits[pos_ff];
      cur_len    = itre_pkg::digit_len(cur_digit);
      cur_sym    = itre_pkg::digit_symbol(cur_digit, k_ff, pos_ff);
      after      = itre_pkg::find_nonzero(cur_ff.digits, {1'b0, pos_ff} + 3'd1);
      first      = itre_pkg::find_nonzero(head.entry.digits, 3'd0);
      digit_done = ({1'b0, k_ff} == cur_len - 3'd1);
      last_sym   = cur_ff.err || (digit_done && !after[2]);
      out_free   = !rsp_valid_ff || !rsp_stall;
      emit       = busy_ff && out_free;
      // next entry loads as the current one hands over its last symbol
      load       = head.valid && (!busy_ff || (emit && last_sym));
      pop        = load;

      busy_in       = busy_ff;
      cur_in        = cur_ff;
      pos_in        = pos_ff;
      k_in          = k_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_err_in    = rsp_err_ff;

      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_symbol_in = cur_ff.err ? itre_pkg::SYM_I : cur_sym;
         rsp_last_in   = last_sym;
         rsp_err_in    = cur_ff.err;
         if (last_sym) begin
            busy_in = 1'b0;
         end else if (digit_done) begin
            pos_in = after[1:0];
            k_in   = 2'd0;
         end else begin
            k_in = k_ff + 2'd1;
         end
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end

      if (load) begin
         busy_in = 1'b1;
         cur_in  = head.entry;
         pos_in  = first[1:0];
         k_in    = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      pos_ff        <= pos_in;
      k_ff          <= k_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_symbol      = rsp_symbol_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_range_error = rsp_err_ff;

   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_last_ff && rsp_symbol_ff == itre_pkg::SYM_I))
      else $error("range error beat not a single I with last");

   a_sym_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_symbol_ff <= itre_pkg::SYM_M))
      else $error("symbol code out of range");

   a_live_digit: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !cur_ff.err) |-> (cur_len != 3'd0 && {1'b0, k_ff} < cur_len))
      else $error("sequencer sits on an empty digit");

   a_pop_turn: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && pop) |-> (emit && last_sym))
      else $error("entry replaced before its last symbol");

endmodule

[src/integer_to_roman_encoder_unit.sv]
// ----------------------------------------------------------------------------
// integer_to_roman_encoder_unit
// Converts a 12-bit unsigned integer into its roman numeral as a stream
// of symbol beats, most significant symbol first.
// ----------------------------------------------------------------------------
// usage
//   req channel: one beat carries req_value, taken when req_valid and not
//   req_stall. rsp channel: one beat per symbol (0=I 1=V 2=X 3=L 4=C 5=D
//   6=M), rsp_last marks the final symbol of a value. a value of zero or
//   above 3999 gives a single beat with rsp_range_error, symbol I, last.
// timing
//   when the block is idle, a taken req beat passes through the queue, the
//   sequencer's entry register and the result register before its first
//   symbol shows; symbols then follow one per cycle while rsp_stall is low,
//   with no gap between values. 3888 gives the longest run, 15 symbols.
// flow control
//   the front classifies and splits each value into decimal digits and
//   writes it into a small queue; req_stall is high only while that queue
//   is full. the back stage holds a registered output, so a stalled rsp
//   beat stays put while the queue takes new values until it is full.
// reset
//   synchronous, active high; clears the queue and drops rsp_valid.
// ----------------------------------------------------------------------------
module integer_to_roman_encoder_unit #(
   parameter int QueueDepth = itre_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [itre_pkg::VALUE_W-1:0]  req_value,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [itre_pkg::SYMBOL_W-1:0] rsp_symbol,
   output logic                          rsp_last,
   output logic                          rsp_range_error
);

   itre_pkg::entry_type front_entry;   // classified value, digits split
   itre_pkg::head_type  queue_head;    // oldest waiting value
   logic                queue_full;
   logic                queue_pop;

   // front: range check and decimal split, purely combinational
   itre_front u_front (
      .value (req_value),
      .entry (front_entry)
   );

   // decoupling queue; its fill level is the only source of req_stall
   itre_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_entry (front_entry),
      .full       (queue_full),
      .head       (queue_head),
      .pop        (queue_pop)
   );

   assign req_stall = queue_full;

   // back: symbol sequencer with registered result beat
   itre_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (queue_head),
      .pop             (queue_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_symbol      (rsp_symbol),
      .rsp_last        (rsp_last),
      .rsp_range_error (rsp_range_error)
   );

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for integer_to_roman_encoder_unit. Sends integers over the req
// channel and checks every rsp beat against symbol runs predicted here from
// the decimal digits of each value accepted. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb;

   localparam int VALUE_W     = itre_pkg::VALUE_W;
   localparam int SYMBOL_W    = itre_pkg::SYMBOL_W;
   localparam int DIGITS      = itre_pkg::DIGITS;

   localparam int CLOCK_HALF  = 6;
   localparam int RESET_TICKS = 10;
   localparam int ITEM_COUNT  = 410;
   localparam int QUIET_TAIL  = 60;     // final items sent with no idling at all
   localparam int HANG_LIMIT  = 2000;   // cycles with no beat on either side
   localparam int DRAIN_TICKS = 8;
   localparam int REPORT_MAX  = 10;

   // one expected rsp beat
   typedef struct {
      logic [SYMBOL_W-1:0] symbol;
      logic                last;
      logic                range_error;
   } symbol_beat_type;

   // holds the symbol runs still owed by the block and checks beats in order
   class numeral_board;
      symbol_beat_type pending_symbols[$];
      int              fail_count    = 0;
      int              symbols_seen  = 0;
      int              values_noted  = 0;
      int              out_of_range  = 0;

      function void push_symbol(input logic [SYMBOL_W-1:0] s);
         symbol_beat_type b;
         b.symbol      = s;
         b.last        = 1'b0;
         b.range_error = 1'b0;
         pending_symbols.push_back(b);
      endfunction

      // spell one accepted value as roman symbols, thousands first
      function void note_value(input logic [VALUE_W-1:0] v);
         symbol_beat_type     b;
         int unsigned         scale;
         int unsigned         d;
         logic [SYMBOL_W-1:0] one_s;
         logic [SYMBOL_W-1:0] five_s;
         logic [SYMBOL_W-1:0] ten_s;
         values_noted++;
         if (v == '0 || v > itre_pkg::MAX_VALUE) begin
            out_of_range++;
            b.symbol      = itre_pkg::SYM_I;
            b.last        = 1'b1;
            b.range_error = 1'b1;
            pending_symbols.push_back(b);
            return;
         end
         scale = 1000;
         for (int place = 0; place < DIGITS; place++) begin
            d = (int'(v) / scale) % 10;
            case (place)
               0: begin
                  one_s = itre_pkg::SYM_M; five_s = itre_pkg::SYM_M; ten_s = itre_pkg::SYM_M;
               end
               1: begin
                  one_s = itre_pkg::SYM_C; five_s = itre_pkg::SYM_D; ten_s = itre_pkg::SYM_M;
               end
               2: begin
                  one_s = itre_pkg::SYM_X; five_s = itre_pkg::SYM_L; ten_s = itre_pkg::SYM_C;
               end
               default: begin
                  one_s = itre_pkg::SYM_I; five_s = itre_pkg::SYM_V; ten_s = itre_pkg::SYM_X;
               end
            endcase
            case (d)
               1, 2, 3: begin
                  repeat (d) push_symbol(one_s);
               end
               4: begin
                  push_symbol(one_s);
                  push_symbol(five_s);
               end
               5: begin
                  push_symbol(five_s);
               end
               6, 7, 8: begin
                  push_symbol(five_s);
                  repeat (d - 5) push_symbol(one_s);
               end
               9: begin
                  push_symbol(one_s);
                  push_symbol(ten_s);
               end
               default: ;
            endcase
            scale = scale / 10;
         end
         pending_symbols[pending_symbols.size() - 1].last = 1'b1;
      endfunction

      function void check_symbol(input logic [SYMBOL_W-1:0] s, input logic l,
                                 input logic e);
         symbol_beat_type want;
         symbols_seen++;
         if (pending_symbols.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
               $display("tb: rsp beat with nothing owed: sym %0d last %0b err %0b",
                        s, l, e);
            return;
         end
         want = pending_symbols.pop_front();
         if (s !== want.symbol || l !== want.last || e !== want.range_error) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
               $display("tb: mismatch, want sym %0d last %0b err %0b, %s %0d %0b %0b",
                        want.symbol, want.last, want.range_error,
                        "got sym/last/err", s, l, e);
         end
      endfunction

      function int pending();
         return pending_symbols.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [VALUE_W-1:0]  req_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [SYMBOL_W-1:0] rsp_symbol;
   logic                rsp_last;
   logic                rsp_range_error;

   numeral_board board = new();

   // calm: the directed values and stretches of the random part, without idling
   // quiet: the tail of the run, no idling on either side
   bit calm  = 1'b0;
   bit quiet = 1'b0;
   int hang_ticks = 0;

   integer_to_roman_encoder_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_symbol      (rsp_symbol),
      .rsp_last        (rsp_last),
      .rsp_range_error (rsp_range_error)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // result side: every taken rsp beat goes to the board
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_symbol(rsp_symbol, rsp_last, rsp_range_error);
   end

   // hang detection: count cycles where neither channel moves a beat
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         hang_ticks <= 0;
      else
         hang_ticks <= hang_ticks + 1;
   end

   initial begin
      while (hang_ticks < HANG_LIMIT)
         @(posedge clock);
      $display("tb: no progress for %0d cycles", HANG_LIMIT);
      $display("tb: failure");
      $finish;
   end

   // receiver back-pressure: random stall bursts, changed at the falling edge
   // only, never while calm or in the tail
   initial begin
      int burst;
      forever begin
         @(negedge clock);
         if (!reset && !calm && !quiet && $urandom_range(0, 6) == 0) begin
            burst = $urandom_range(1, 17);
            rsp_stall = 1'b1;
            repeat (burst) @(negedge clock);
         end
         rsp_stall = 1'b0;
      end
   end

   // present one value from a falling edge and hold it until taken;
   // valid stays high into the next value unless a gap is chosen
   task automatic send_value(input logic [VALUE_W-1:0] v);
      int gap;
      if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_value = v;
      do
         @(posedge clock);
      while (req_stall);
      board.note_value(v);
      @(negedge clock);
   endtask

   // mostly in-range values built digit by digit, so every digit pattern shows
   // up below the thousands; the rest is zero, too large, or any 12-bit value
   function automatic logic [VALUE_W-1:0] pick_value();
      int unsigned th;
      int unsigned hu;
      int unsigned te;
      int unsigned un;
      case ($urandom_range(0, 19))
         0:       return '0;
         1, 2:    return VALUE_W'($urandom_range(4000, 4095));
         3, 4:    return VALUE_W'($urandom_range(0, 4095));
         default: begin
            th = $urandom_range(0, 3);
            hu = $urandom_range(0, 9);
            te = $urandom_range(0, 9);
            un = $urandom_range(0, 9);
            return VALUE_W'(th * 1000 + hu * 100 + te * 10 + un);
         end
      endcase
   endfunction

   initial begin
      logic [VALUE_W-1:0] directed[$];
      int                 leftover;

      // bounds, zero and overflow errors, the longest run, each subtractive
      // form at each place below the thousands, and alternating bit patterns
      directed = '{12'd1, 12'd3999, 12'd0, 12'd4000, 12'd4095, 12'd3888,
                   12'd4, 12'd9, 12'd5, 12'd8, 12'd40, 12'd90, 12'd400,
                   12'd900, 12'd1000, 12'd3000, 12'd14, 12'd49, 12'd1994,
                   12'd444, 12'd999, 12'd2048, 12'd1365, 12'd2730, 12'd3};

      repeat (RESET_TICKS) @(negedge clock);
      reset = 1'b0;

      // directed values go back to back
      calm = 1'b1;
      foreach (directed[i])
         send_value(directed[i]);
      calm = 1'b0;

      for (int n = directed.size(); n < ITEM_COUNT; n++) begin
         if (n % 40 == 0)
            calm = ($urandom_range(0, 3) == 0);
         if (n >= ITEM_COUNT - QUIET_TAIL)
            quiet = 1'b1;
         send_value(pick_value());
      end
      req_valid = 1'b0;

      while (board.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_TICKS) @(posedge clock);

      leftover = board.pending();
      if (leftover != 0)
         $display("tb: %0d symbols never arrived", leftover);
      if (board.fail_count > REPORT_MAX)
         $display("tb: %0d mismatches in all", board.fail_count);
      $display("tb: converted %0d values (%0d out of range), checked %0d symbol beats",
               board.values_noted, board.out_of_range, board.symbols_seen);
      $display("tb: idle bursts on both channels, then a back-to-back tail");
      if (board.fail_count == 0 && leftover == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
